@@ rtl/atan2_turns_approximation_macros.svh @@
// Assertion macros shared by the angle pipeline modules.
`ifndef ATAN2_TURNS_APPROXIMATION_MACROS_SVH
`define ATAN2_TURNS_APPROXIMATION_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define A2T_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define A2T_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/a2t_pkg.sv @@
// Shared types and constants of the atan2 angle pipeline.
package a2t_pkg;

    localparam int IN_W      = 16;
    localparam int MAG_W     = 17;
    localparam int Q_W       = 17;
    localparam int FRAC_BITS = 16;
    localparam int ANG_W     = 16;
    localparam int P1_W      = 29;
    localparam int INNER_W   = 14;
    localparam int P2_W      = 31;
    localparam int BASE_W    = 15;

    localparam logic [INNER_W-1:0] COEF_A       = 14'd8192;
    localparam logic [11:0]        COEF_B       = 12'd2847;
    localparam logic [Q_W:0]       Q_ONE        = 18'd65536;
    localparam logic [ANG_W-1:0]   TURN_QUARTER = 16'd16384;
    localparam logic [ANG_W-1:0]   TURN_HALF    = 16'd32768;

    // Per-item flags carried alongside the data.
    typedef struct packed {
        logic zero;     // origin
        logic oct_lo;   // |x| >= |y|
        logic xneg;
        logic yneg;
    } t_side;

endpackage

@@ rtl/a2t_front.sv @@
// Input stage: magnitudes, max/min sort and octant flags.
module a2t_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [a2t_pkg::IN_W-1:0]     i_y_coord,
    input  logic [a2t_pkg::IN_W-1:0]     i_x_coord,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [a2t_pkg::MAG_W-1:0]    o_mx,
    output logic [a2t_pkg::MAG_W-1:0]    o_mn,
    output a2t_pkg::t_side               o_side
);

    logic                         r_v;
    logic [a2t_pkg::MAG_W-1:0]    r_mx, r_mn;
    a2t_pkg::t_side               r_side;
    logic [a2t_pkg::MAG_W-1:0]    w_ay, w_ax;
    logic                         w_en;

    // -32768 maps to 32768, kept exactly in 17 bits
    assign w_ay = i_y_coord[a2t_pkg::IN_W-1]
                ? a2t_pkg::MAG_W'(a2t_pkg::Q_ONE[a2t_pkg::MAG_W-1:0] - {1'b0, i_y_coord})
                : {1'b0, i_y_coord};
    assign w_ax = i_x_coord[a2t_pkg::IN_W-1]
                ? a2t_pkg::MAG_W'(a2t_pkg::Q_ONE[a2t_pkg::MAG_W-1:0] - {1'b0, i_x_coord})
                : {1'b0, i_x_coord};

    assign w_en    = !r_v || !i_stall;
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mx          <= (w_ax > w_ay) ? w_ax : w_ay;
            r_mn          <= (w_ax > w_ay) ? w_ay : w_ax;
            r_side.zero   <= (w_ax == '0) && (w_ay == '0);
            r_side.oct_lo <= (w_ax >= w_ay);
            r_side.xneg   <= i_x_coord[a2t_pkg::IN_W-1];
            r_side.yneg   <= i_y_coord[a2t_pkg::IN_W-1];
        end
    end

    assign o_valid = r_v;
    assign o_mx    = r_mx;
    assign o_mn    = r_mn;
    assign o_side  = r_side;

`include "atan2_turns_approximation_macros.svh"

    `A2T_CHECK(a_sorted, r_v, r_mn <= r_mx, "front: min above max")

endmodule

@@ rtl/a2t_div.sv @@
// Pipelined restoring divider: one quotient bit of min*2^16/max per stage.
module a2t_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [a2t_pkg::MAG_W-1:0]    i_mx,
    input  logic [a2t_pkg::MAG_W-1:0]    i_mn,
    input  a2t_pkg::t_side               i_side,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [a2t_pkg::Q_W-1:0]      o_ratio,
    output a2t_pkg::t_side               o_side
);

    localparam int N = a2t_pkg::Q_W;

    logic [N-1:0]                 r_v;
    logic [a2t_pkg::MAG_W-1:0]    r_rem  [N];
    logic [a2t_pkg::MAG_W-1:0]    r_mx   [N];
    logic [a2t_pkg::Q_W-1:0]      r_q    [N];
    a2t_pkg::t_side               r_side [N];

    logic [a2t_pkg::MAG_W-1:0]    n_rem  [N];
    logic [a2t_pkg::MAG_W-1:0]    n_mx   [N];
    logic [a2t_pkg::Q_W-1:0]      n_q    [N];
    a2t_pkg::t_side               n_side [N];
    logic [N-1:0]                 n_v;
    logic [N:0]                   w_en;

    // bubbles collapse: a stage moves when empty or when the next one moves
    always_comb begin
        w_en[N] = !i_stall;
        for (int k = N - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end
    assign o_stall = !w_en[0];

    // first stage compares min itself (top quotient bit, set only when min == max);
    // later stages shift the partial remainder, which stays below max unless max is zero
    always_comb begin
        logic [a2t_pkg::MAG_W-1:0] trial;
        logic [a2t_pkg::Q_W-1:0]   q_in;
        logic                      ge;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                trial     = i_mn;
                q_in      = '0;
                n_mx[k]   = i_mx;
                n_side[k] = i_side;
                n_v[k]    = i_valid;
            end else begin
                trial     = {r_rem[k-1][a2t_pkg::MAG_W-2:0], 1'b0};
                q_in      = r_q[k-1];
                n_mx[k]   = r_mx[k-1];
                n_side[k] = r_side[k-1];
                n_v[k]    = r_v[k-1];
            end
            ge       = (trial >= n_mx[k]);
            n_rem[k] = ge ? a2t_pkg::MAG_W'(trial - n_mx[k]) : trial;
            n_q[k]   = {q_in[a2t_pkg::Q_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            if (w_en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_mx[k]   <= n_mx[k];
                r_q[k]    <= n_q[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_ratio = r_q[N-1];
    assign o_side  = r_side[N-1];

`include "atan2_turns_approximation_macros.svh"

    `A2T_CHECK(a_ratio_max, r_v[N-1] && !r_side[N-1].zero, {1'b0, r_q[N-1]} <= a2t_pkg::Q_ONE, "div: ratio above one")
    `A2T_CHECK(a_rem_below, r_v[N-1] && !r_side[N-1].zero, r_rem[N-1] < r_mx[N-1], "div: remainder not reduced")
    `A2T_CHECK_NEXT(a_advance, r_v[0] && w_en[0] && w_en[1], r_mx[1] == $past(r_mx[0]), "div: stage lost its divisor")

endmodule

@@ rtl/a2t_poly.sv @@
// Octant polynomial (two multiply stages) and quadrant fold into the output register.
module a2t_poly (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [a2t_pkg::Q_W-1:0]      i_ratio,
    input  a2t_pkg::t_side               i_side,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [a2t_pkg::ANG_W-1:0]    o_angle_turns
);

    logic                            r1_v, r2_v, r3_v;
    logic [a2t_pkg::Q_W-1:0]         r1_ratio;
    logic [a2t_pkg::P1_W-1:0]        r1_prod;
    a2t_pkg::t_side                  r1_side, r2_side;
    logic [a2t_pkg::P2_W-1:0]        r2_prod;
    logic [a2t_pkg::ANG_W-1:0]       r3_angle;

    logic                            w_en1, w_en2, w_en3;
    logic [a2t_pkg::Q_W-1:0]         w_comp;
    logic [a2t_pkg::INNER_W-1:0]     w_inner;
    logic [a2t_pkg::BASE_W-1:0]      w_base;
    logic [a2t_pkg::ANG_W-1:0]       n_oct, n_half, n_angle;

    assign w_en3   = !r3_v || !i_stall;
    assign w_en2   = !r2_v || w_en3;
    assign w_en1   = !r1_v || w_en2;
    assign o_stall = !w_en1;

    // 1 - ratio, then 2847 * (1 - ratio)
    assign w_comp  = a2t_pkg::Q_W'(a2t_pkg::Q_ONE - {1'b0, i_ratio});
    // 1/8 + truncated coefficient term
    assign w_inner = a2t_pkg::COEF_A
                   + a2t_pkg::INNER_W'(r1_prod[a2t_pkg::P1_W-1:a2t_pkg::FRAC_BITS]);
    assign w_base  = r2_prod[a2t_pkg::P2_W-1:a2t_pkg::FRAC_BITS];

    // reflect into octant, left half plane, lower half plane (mod 2^16)
    always_comb begin
        n_oct   = r2_side.oct_lo ? a2t_pkg::ANG_W'(w_base)
                                 : a2t_pkg::ANG_W'(a2t_pkg::TURN_QUARTER - a2t_pkg::ANG_W'(w_base));
        n_half  = r2_side.xneg ? a2t_pkg::ANG_W'(a2t_pkg::TURN_HALF - n_oct) : n_oct;
        n_angle = r2_side.yneg ? a2t_pkg::ANG_W'(16'd0 - n_half) : n_half;
        if (r2_side.zero) begin
            n_angle = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (w_en1) begin
                r1_v <= i_valid;
            end
            if (w_en2) begin
                r2_v <= r1_v;
            end
            if (w_en3) begin
                r3_v <= r2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_ratio <= i_ratio;
            r1_prod  <= a2t_pkg::P1_W'(a2t_pkg::COEF_B * w_comp);
            r1_side  <= i_side;
        end
        if (w_en2) begin
            r2_prod <= a2t_pkg::P2_W'(r1_ratio * w_inner);
            r2_side <= r1_side;
        end
        if (w_en3) begin
            r3_angle <= n_angle;
        end
    end

    assign o_valid       = r3_v;
    assign o_angle_turns = r3_angle;

`include "atan2_turns_approximation_macros.svh"

    `A2T_CHECK(a_base_octant, r2_v && !r2_side.zero, w_base <= a2t_pkg::BASE_W'(a2t_pkg::COEF_A), "poly: base past one eighth turn")

endmodule

@@ rtl/atan2_turns_approximation.sv @@
// Top level of the four-quadrant atan2 pipeline, angle in turns.
// The block takes a signed 16-bit vector (y, x) and returns its angle as an
// unsigned Q0.16 fraction of a full turn (16384 = quarter turn, 32768 = half,
// 0 along +x, 0 for the origin). Flow: one register stage forms |x|, |y| and
// sorts them; a 17-stage restoring divider produces r = floor(min*2^16/max),
// one quotient bit per stage (r = 65536 when |x| = |y|); two multiply stages
// evaluate r*(1/8 + 2847/65536*(1-r)) with truncation; the last stage folds
// the octant value into the right octant/quadrant and holds the result in the
// output register. One item enters per clock while o_stall is low
// (throughput 1 item/cycle). Every stage moves on its own valid bit, so
// bubbles collapse and a stalled output still lets upstream stages fill.
// The longest per-stage logic is one 17-bit compare/subtract in the
// divider or one 17x14 multiply in the polynomial.
module atan2_turns_approximation (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input item
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [15:0]  i_y_coord,
    input  logic [15:0]  i_x_coord,
    // result item
    output logic         o_valid,
    input  logic         i_stall,
    output logic [15:0]  o_angle_turns
);

    // front -> divider
    logic                         w_fr_valid, w_fr_stall;
    logic [a2t_pkg::MAG_W-1:0]    w_fr_mx, w_fr_mn;
    a2t_pkg::t_side               w_fr_side;

    // divider -> polynomial
    logic                         w_dv_valid, w_dv_stall;
    logic [a2t_pkg::Q_W-1:0]      w_dv_ratio;
    a2t_pkg::t_side               w_dv_side;

    a2t_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_y_coord (i_y_coord),
        .i_x_coord (i_x_coord),
        .o_valid   (w_fr_valid),
        .i_stall   (w_fr_stall),
        .o_mx      (w_fr_mx),
        .o_mn      (w_fr_mn),
        .o_side    (w_fr_side)
    );

    a2t_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_stall (w_fr_stall),
        .i_mx    (w_fr_mx),
        .i_mn    (w_fr_mn),
        .i_side  (w_fr_side),
        .o_valid (w_dv_valid),
        .i_stall (w_dv_stall),
        .o_ratio (w_dv_ratio),
        .o_side  (w_dv_side)
    );

    // polynomial, fold and the output register
    a2t_poly u_poly (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_dv_valid),
        .o_stall       (w_dv_stall),
        .i_ratio       (w_dv_ratio),
        .i_side        (w_dv_side),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_angle_turns (o_angle_turns)
    );

endmodule
